// File: rtl/core/fbf_pkg.sv
// Shared constants and types of the four-channel FIR filter bank.
package fbf_pkg;

   localparam int SAMPLE_BITS    = 32;
   localparam int OUT_BITS       = 50;
   localparam int TOTAL_BITS     = 64;
   localparam int TAPS_REG_BITS  = 64;
   localparam int FILTER_COUNT   = 4;
   localparam int CSR_INDEX_BITS = 2;
   localparam int DEF_TAP_COUNT  = 4;
   localparam int DEF_COEF_BITS  = 16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TAPS_A,
      CSR_TAPS_B,
      CSR_TAPS_C,
      CSR_TAPS_D
   } csr_index_type;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [TAPS_REG_BITS-1:0]      taps_type;
   typedef logic [TOTAL_BITS-1:0]         acc_type;
   typedef logic signed [OUT_BITS-1:0]    out_type;

   // Control that travels alongside a beat through the pipeline.
   typedef struct packed {
      logic valid;
      logic clr;
   } stage_type;

endpackage

// File: rtl/core/fbf_if.sv
// Handshake channels of the filter bank: sample input, result output and register writes.
interface fbf_req_if import fbf_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample;
   logic       restart;

   modport source (output valid, output sample, output restart, input ready);
   modport sink (input valid, input sample, input restart, output ready);
endinterface

interface fbf_rsp_if import fbf_pkg::*; ();
   logic                         valid;
   logic                         ready;
   out_type                      out_a;
   out_type                      out_b;
   out_type                      out_c;
   out_type                      out_d;
   logic signed [TOTAL_BITS-1:0] running_total;

   modport source (output valid, output out_a, output out_b, output out_c, output out_d,
                   output running_total, input ready);
   modport sink (input valid, input out_a, input out_b, input out_c, input out_d,
                 input running_total, output ready);
endinterface

interface fbf_csr_if import fbf_pkg::*; ();
   logic          valid;
   logic          ready;
   csr_index_type index;
   taps_type      wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

// File: rtl/core/fbf_window.sv
// Sample window, fill tracking and the first pipeline register.
module fbf_window import fbf_pkg::*; #(
   parameter int TAP_COUNT = DEF_TAP_COUNT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       beat,
   input  sample_type sample,
   input  logic       restart,
   input  logic       load,
   output sample_type samples[TAP_COUNT],
   output stage_type  stage
);

   localparam int WIN_DEPTH = TAP_COUNT - 1;
   localparam int FILL_BITS = $clog2(TAP_COUNT);

   sample_type           window_ff[WIN_DEPTH];
   sample_type           window_in[WIN_DEPTH];
   sample_type           samples_ff[TAP_COUNT];
   sample_type           samples_in[TAP_COUNT];
   logic [FILL_BITS-1:0] fill_ff;
   logic [FILL_BITS-1:0] fill_in;
   logic [FILL_BITS-1:0] fill_eff;
   logic                 produce;
   logic                 pending_ff;
   logic                 pending_in;
   stage_type            stage_ff;
   stage_type            stage_in;

   always_comb begin
      fill_eff = restart ? '0 : fill_ff;
      produce  = (fill_eff == FILL_BITS'(WIN_DEPTH));

      window_in[0]  = sample;
      samples_in[0] = sample;
      for (int i = 1; i < WIN_DEPTH; i++) begin
         window_in[i] = window_ff[i-1];
      end
      for (int i = 1; i < TAP_COUNT; i++) begin
         samples_in[i] = window_ff[i-1];
      end

      fill_in = produce ? fill_eff : fill_eff + 1'b1;

      // A restart clears the total; the clear rides on the next beat that gives a result.
      pending_in     = restart | (pending_ff & ~produce);
      stage_in.valid = beat & produce;
      stage_in.clr   = pending_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         pending_ff <= 1'b0;
         stage_ff   <= '0;
      end else begin
         if (beat) begin
            fill_ff    <= fill_in;
            pending_ff <= pending_in;
         end
         if (load) begin
            stage_ff <= stage_in;
         end
      end
   end

   // Old window contents need no clearing: a full refill precedes every result.
   always_ff @(posedge clock) begin
      if (beat) begin
         window_ff <= window_in;
      end
      if (load) begin
         samples_ff <= samples_in;
      end
   end

   assign samples = samples_ff;
   assign stage   = stage_ff;

endmodule

// File: rtl/core/fbf_filter.sv
// One FIR filter: a registered row of tap products, then a registered sum.
module fbf_filter import fbf_pkg::*; #(
   parameter int TAP_COUNT = DEF_TAP_COUNT,
   parameter int COEF_BITS = DEF_COEF_BITS
) (
   input  logic       clock,
   input  taps_type   taps,
   input  sample_type samples[TAP_COUNT],
   input  logic       load_prod,
   input  logic       load_acc,
   output acc_type    acc
);

   localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
   localparam int PAD_BITS  = TAP_COUNT * COEF_BITS;

   // Taps that fall past the register read as zero, including a missing sign bit.
   logic [PAD_BITS+TAPS_REG_BITS-1:0] taps_pad;
   logic signed [COEF_BITS-1:0]       coef[TAP_COUNT];
   logic signed [PROD_BITS-1:0]       prod_ff[TAP_COUNT];
   logic signed [PROD_BITS-1:0]       prod_in[TAP_COUNT];
   acc_type                           acc_ff;
   acc_type                           acc_in;

   assign taps_pad = {{PAD_BITS{1'b0}}, taps};

   always_comb begin
      for (int k = 0; k < TAP_COUNT; k++) begin
         coef[k]    = taps_pad[k*COEF_BITS +: COEF_BITS];
         prod_in[k] = PROD_BITS'(samples[k]) * PROD_BITS'(coef[k]);
      end
   end

   always_comb begin
      acc_in = '0;
      for (int k = 0; k < TAP_COUNT; k++) begin
         acc_in = acc_in + TOTAL_BITS'(prod_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (load_prod) begin
         prod_ff <= prod_in;
      end
      if (load_acc) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

// File: rtl/core/fbf_total.sv
// Result register: the four filter outputs and the wrapping running total.
module fbf_total import fbf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  stage_type stage,
   input  acc_type   acc[FILTER_COUNT],
   input  logic      load,
   output logic      valid,
   output out_type   outs[FILTER_COUNT],
   output acc_type   total
);

   logic    valid_ff;
   acc_type total_ff;
   acc_type total_in;
   out_type outs_ff[FILTER_COUNT];

   always_comb begin
      total_in = stage.clr ? '0 : total_ff;
      for (int f = 0; f < FILTER_COUNT; f++) begin
         total_in = total_in + acc[f];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         total_ff <= '0;
      end else if (load) begin
         valid_ff <= stage.valid;
         if (stage.valid) begin
            total_ff <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load && stage.valid) begin
         for (int f = 0; f < FILTER_COUNT; f++) begin
            outs_ff[f] <= acc[f][OUT_BITS-1:0];
         end
      end
   end

   assign valid = valid_ff;
   assign outs  = outs_ff;
   assign total = total_ff;

endmodule

// File: rtl/core/fir_bank_four_channel.sv
// Four FIR filters over one shared sample window, with a wrapping total of all outputs.
// The block takes one sample per clock unless the result side stalls it. A result passes
// through four register stages: the sample window, the tap products, the per-filter sums and
// the result register that also holds the running total. Each stage holds while it is full
// and the one after it cannot load, so bubbles are squeezed out and a new sample is taken
// while a result waits as long as some stage is empty. After reset or a beat with restart
// set, the first TAP_COUNT-1 samples only fill the window and give no result. The user must
// write tap registers through the csr channel while the block is idle; it does not check.
module fir_bank_four_channel import fbf_pkg::*; #(
   parameter int TAP_COUNT = DEF_TAP_COUNT,
   parameter int COEF_BITS = DEF_COEF_BITS
) (
   input logic        clock,
   input logic        reset,
   fbf_req_if.sink    req_bus,
   fbf_rsp_if.source  rsp_bus,
   fbf_csr_if.sink    csr_bus
);

   taps_type   taps_ff[FILTER_COUNT];
   sample_type samples[TAP_COUNT];
   stage_type  st1;
   stage_type  st2_ff;
   stage_type  st3_ff;
   acc_type    acc[FILTER_COUNT];
   out_type    outs[FILTER_COUNT];
   acc_type    total;
   logic       out_valid;
   logic       en_out;
   logic       en3;
   logic       en2;
   logic       en1;
   logic       req_beat;

   // Tap registers.
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int f = 0; f < FILTER_COUNT; f++) begin
            taps_ff[f] <= '0;
         end
      end else if (csr_bus.valid) begin
         taps_ff[csr_bus.index] <= csr_bus.wdata;
      end
   end

   // Each stage loads when it is empty or the stage after it loads.
   always_comb begin
      en_out = !out_valid || rsp_bus.ready;
      en3    = !st3_ff.valid || en_out;
      en2    = !st2_ff.valid || en3;
      en1    = !st1.valid || en2;
   end

   assign req_bus.ready = en1;
   assign req_beat      = req_bus.valid && en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         st2_ff <= '0;
         st3_ff <= '0;
      end else begin
         if (en2) begin
            st2_ff <= st1;
         end
         if (en3) begin
            st3_ff <= st2_ff;
         end
      end
   end

   fbf_window #(
      .TAP_COUNT (TAP_COUNT)
   ) u_window (
      .clock   (clock),
      .reset   (reset),
      .beat    (req_beat),
      .sample  (req_bus.sample),
      .restart (req_bus.restart),
      .load    (en1),
      .samples (samples),
      .stage   (st1)
   );

   for (genvar f = 0; f < FILTER_COUNT; f++) begin : g_filter
      fbf_filter #(
         .TAP_COUNT (TAP_COUNT),
         .COEF_BITS (COEF_BITS)
      ) u_filter (
         .clock     (clock),
         .taps      (taps_ff[f]),
         .samples   (samples),
         .load_prod (en2),
         .load_acc  (en3),
         .acc       (acc[f])
      );
   end

   fbf_total u_total (
      .clock (clock),
      .reset (reset),
      .stage (st3_ff),
      .acc   (acc),
      .load  (en_out),
      .valid (out_valid),
      .outs  (outs),
      .total (total)
   );

   assign rsp_bus.valid         = out_valid;
   assign rsp_bus.out_a         = outs[0];
   assign rsp_bus.out_b         = outs[1];
   assign rsp_bus.out_c         = outs[2];
   assign rsp_bus.out_d         = outs[3];
   assign rsp_bus.running_total = $signed(total);

endmodule

// File: verif/fir_bank_four_channel_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the four-channel FIR filter bank with a result scoreboard.
module fir_bank_four_channel_tb;
   import fbf_pkg::*;

   localparam int WIN_DEPTH   = DEF_TAP_COUNT - 1;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_BEATS = 212;

   typedef struct packed {
      logic [FILTER_COUNT-1:0][OUT_BITS-1:0] outs;
      logic [TOTAL_BITS-1:0]                 total;
   } filter_result_type;

   class fir_bank_scoreboard;
      taps_type              taps [FILTER_COUNT];
      sample_type            window [WIN_DEPTH];
      int unsigned           fill_level;
      logic [TOTAL_BITS-1:0] total;
      filter_result_type     expected_q [$];
      int unsigned           mismatches;

      function new();
         foreach (taps[i]) taps[i] = '0;
         foreach (window[i]) window[i] = '0;
         fill_level = 0;
         total      = '0;
         mismatches = 0;
      endfunction

      function void set_taps(csr_index_type idx, taps_type value);
         taps[int'(idx)] = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void shift_in(sample_type s);
         for (int i = WIN_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
         window[0] = s;
      endfunction

      // Works out the four filter outputs and the new total for one accepted beat; a fill beat only enters the window.
      function void note_sample(sample_type s, logic restart);
         filter_result_type        res;
         longint                   acc;
         logic signed [31:0]       x;
         logic signed [DEF_COEF_BITS-1:0] coef;
         if (restart) begin
            foreach (window[i]) window[i] = '0;
            fill_level = 0;
            total      = '0;
         end
         if (fill_level < WIN_DEPTH) begin
            shift_in(s);
            fill_level++;
            return;
         end
         for (int f = 0; f < FILTER_COUNT; f++) begin
            acc = 0;
            for (int k = 0; k < DEF_TAP_COUNT; k++) begin
               x    = (k == 0) ? s : window[k-1];
               coef = taps[f][DEF_COEF_BITS*k +: DEF_COEF_BITS];
               acc += longint'(x) * longint'(coef);
            end
            total       += acc;
            res.outs[f]  = acc[OUT_BITS-1:0];
         end
         res.total = total;
         expected_q.push_back(res);
         shift_in(s);
      endfunction

      function void flag(string field, logic [TOTAL_BITS-1:0] exp_v,
                         logic [TOTAL_BITS-1:0] act_v);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s expected %h, got %h", $realtime, field, exp_v, act_v);
      endfunction

      function void check_result(filter_result_type act);
         filter_result_type exp_r;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result beat, total %h", $realtime, act.total);
            return;
         end
         exp_r = expected_q.pop_front();
         for (int f = 0; f < FILTER_COUNT; f++)
            if (exp_r.outs[f] !== act.outs[f])
               flag($sformatf("out_%c", "a" + f), exp_r.outs[f], act.outs[f]);
         if (exp_r.total !== act.total) flag("running_total", exp_r.total, act.total);
      endfunction
   endclass

   logic clock;
   logic reset;
   int unsigned cycles;
   int unsigned gap_rate;
   int unsigned stall_rate;
   fir_bank_scoreboard sb;

   fbf_req_if req_bus ();
   fbf_rsp_if rsp_bus ();
   fbf_csr_if csr_bus ();

   fir_bank_four_channel DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Watches all three channels; every accepted beat updates the scoreboard.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) sb.set_taps(csr_bus.index, csr_bus.wdata);
         if (req_bus.valid && req_bus.ready) sb.note_sample(req_bus.sample, req_bus.restart);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_result({rsp_bus.out_d, rsp_bus.out_c, rsp_bus.out_b, rsp_bus.out_a,
                             rsp_bus.running_total});
      end
   end

   // Result side back-pressure in random bursts.
   initial begin
      rsp_bus.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (stall_rate != 0 && $urandom_range(1, stall_rate) == 1) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic send_sample(sample_type s, logic restart);
      req_bus.valid   <= 1'b1;
      req_bus.sample  <= s;
      req_bus.restart <= restart;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (gap_rate != 0 && $urandom_range(1, gap_rate) == 1) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic stop_and_drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Fill beats leave nothing in the queue, so give the pipeline time to empty.
   task automatic write_taps(csr_index_type idx, taps_type value);
      repeat (8) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic taps_type pick_taps();
      taps_type v;
      for (int k = 0; k < DEF_TAP_COUNT; k++) begin
         case ($urandom_range(0, 5))
            0:       v[DEF_COEF_BITS*k +: DEF_COEF_BITS] = 16'h8000;
            1:       v[DEF_COEF_BITS*k +: DEF_COEF_BITS] = 16'h7FFF;
            2:       v[DEF_COEF_BITS*k +: DEF_COEF_BITS] = 16'h0000;
            3:       v[DEF_COEF_BITS*k +: DEF_COEF_BITS] = 16'hFFFF;
            default: v[DEF_COEF_BITS*k +: DEF_COEF_BITS] = 16'($urandom);
         endcase
      end
      return v;
   endfunction

   function automatic sample_type pick_sample();
      case ($urandom_range(0, 11))
         0:       return sample_type'(32'h8000_0000);
         1:       return sample_type'(32'h7FFF_FFFF);
         2:       return '0;
         3:       return '1;
         default: return sample_type'($urandom);
      endcase
   endfunction

   initial begin
      sb         = new();
      cycles     = 0;
      gap_rate   = 0;
      stall_rate = 0;
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.sample  <= '0;
      req_bus.restart <= 1'b0;
      csr_bus.valid   <= 1'b0;
      csr_bus.index   <= CSR_TAPS_A;
      csr_bus.wdata   <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: extreme taps against extreme samples, restarts while filling
      // and once the window is full.
      write_taps(CSR_TAPS_A, {4{16'h8000}});
      write_taps(CSR_TAPS_B, {4{16'h7FFF}});
      write_taps(CSR_TAPS_C, 64'h0001_FFFF_8000_7FFF);
      write_taps(CSR_TAPS_D, '1);
      repeat (4) send_sample(sample_type'(32'h7FFF_FFFF), 1'b0);
      repeat (4) send_sample(sample_type'(32'h8000_0000), 1'b0);
      send_sample('0, 1'b0);
      send_sample('1, 1'b0);
      send_sample(sample_type'(1), 1'b0);
      send_sample(sample_type'(32'h8000_0000), 1'b1);
      send_sample(sample_type'(32'h7FFF_FFFF), 1'b0);
      send_sample(sample_type'(-5), 1'b1);
      send_sample(sample_type'(32'h8000_0000), 1'b0);
      send_sample(sample_type'(32'h7FFF_FFFF), 1'b0);
      send_sample(sample_type'(12345), 1'b0);
      send_sample(sample_type'(-777), 1'b0);
      send_sample(sample_type'(32'h7FFF_FFFF), 1'b1);
      send_sample(sample_type'(3), 1'b0);
      send_sample(sample_type'(32'h8000_0000), 1'b0);
      send_sample('1, 1'b0);
      stop_and_drain();

      for (int phase = 0; phase < 4; phase++) begin
         if (phase == 1) begin
            write_taps(CSR_TAPS_A, '0);
            write_taps(CSR_TAPS_B, '1);
            write_taps(CSR_TAPS_C, {4{16'h8000}});
            write_taps(CSR_TAPS_D, {4{16'h7FFF}});
         end else begin
            for (int i = 0; i < FILTER_COUNT; i++)
               write_taps(csr_index_type'(i), pick_taps());
         end
         for (int i = 0; i < PHASE_BEATS; i++) begin
            // The last phase runs at full rate, and each phase has calm stretches.
            if (phase == 3 || (i % 70) >= 50) begin
               gap_rate   = 0;
               stall_rate = 0;
            end else begin
               gap_rate   = 5;
               stall_rate = 6;
            end
            if (phase == 1 && i == 100) stop_and_drain();
            send_sample(pick_sample(), $urandom_range(0, 39) == 0);
         end
         stop_and_drain();
      end

      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/fbf_pkg.sv
rtl/core/fbf_if.sv
rtl/core/fbf_window.sv
rtl/core/fbf_filter.sv
rtl/core/fbf_total.sv
rtl/core/fir_bank_four_channel.sv
verif/fir_bank_four_channel_tb.sv
